// ===== rtl/dra_pkg.sv =====
// DNS reply A-record parser: shared result types and status codes.
// Used by dra_parser, dra_out_queue and dns_reply_a_record_parser.
`default_nettype none

package dra_pkg;

    localparam int unsigned TDATA_W = 88;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_A        = 3'd1;
    localparam logic [2:0] ST_SHORT       = 3'd2;
    localparam logic [2:0] ST_TXID_BAD    = 3'd3;
    localparam logic [2:0] ST_NOT_REPLY   = 3'd4;
    localparam logic [2:0] ST_RCODE_ERR   = 3'd5;
    localparam logic [2:0] ST_NO_ANSWERS  = 3'd6;

    localparam logic KIND_A_RECORD = 1'b0;
    localparam logic KIND_STATUS   = 1'b1;

    // Everything one reply byte can produce: an A record, a status, or both.
    typedef struct packed {
        logic        emit_a;
        logic        emit_s;
        logic [31:0] addr;
        logic [31:0] ttl;
        logic [2:0]  status;
        logic [3:0]  rcode;
        logic [15:0] count;
    } pair_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] addr;
        logic [31:0] ttl;
        logic [2:0]  status;
        logic [3:0]  rcode;
        logic [15:0] count;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/dra_parser.sv =====
// DNS reply A-record parser: per-byte parse state machine.
// Depends on dra_pkg; emits one pair_t per byte that yields results.
`default_nettype none

module dra_parser (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               byte_en,
    input  wire logic [7:0]         reply_byte,
    input  wire logic               last_byte,
    input  wire logic [15:0]        expected_txid,
    output dra_pkg::pair_t          pair_out,
    output logic                    pair_valid
);

    typedef enum logic [3:0] {
        PH_HEADER       = 4'd0,
        PH_QNAME        = 4'd1,
        PH_QLABEL       = 4'd2,
        PH_QPTR         = 4'd3,
        PH_QFIXED       = 4'd4,
        PH_ANAME        = 4'd5,
        PH_ALABEL       = 4'd6,
        PH_APTR         = 4'd7,
        PH_AFIXED       = 4'd8,
        PH_ARDATA       = 4'd9,
        PH_DONE         = 4'd10,
        PH_REJ_TXID     = 4'd11,
        PH_REJ_NOTREPLY = 4'd12,
        PH_REJ_RCODE    = 4'd13,
        PH_REJ_NOANS    = 4'd14
    } phase_t;

    phase_t      phase_reg, phase_next, phase_step;
    logic [3:0]  hdr_idx_reg, hdr_idx_next;
    logic [15:0] flags_reg, flags_next;
    logic [15:0] reply_id_reg, reply_id_next;
    logic [15:0] qleft_reg, qleft_next;
    logic [15:0] aleft_reg, aleft_next;
    logic [7:0]  label_reg, label_next;
    logic [3:0]  fix_idx_reg, fix_idx_next;
    logic [15:0] rtype_reg, rtype_next;
    logic [31:0] ttl_reg, ttl_next;
    logic [15:0] rdlen_reg, rdlen_next;
    logic [31:0] addr_reg, addr_next;
    logic [15:0] found_reg, found_next;

    logic [15:0] aleft_dec;
    logic [15:0] qleft_dec;
    logic [15:0] rdlen_dec;
    logic [15:0] rdlen_full;
    logic [7:0]  label_dec;
    logic        emit_a;
    logic [2:0]  status;
    logic [3:0]  status_rcode;

    assign aleft_dec  = aleft_reg - 16'd1;
    assign qleft_dec  = qleft_reg - 16'd1;
    assign rdlen_dec  = rdlen_reg - 16'd1;
    assign rdlen_full = {rdlen_reg[7:0], reply_byte};
    assign label_dec  = label_reg - 8'd1;

    always_comb begin
        phase_step    = phase_reg;
        hdr_idx_next  = hdr_idx_reg;
        flags_next    = flags_reg;
        reply_id_next = reply_id_reg;
        qleft_next    = qleft_reg;
        aleft_next    = aleft_reg;
        label_next    = label_reg;
        fix_idx_next  = fix_idx_reg;
        rtype_next    = rtype_reg;
        ttl_next      = ttl_reg;
        rdlen_next    = rdlen_reg;
        addr_next     = addr_reg;
        found_next    = found_reg;
        emit_a        = 1'b0;

        unique case (phase_reg) inside
            PH_HEADER: begin
                case (hdr_idx_reg) inside
                    4'd0, 4'd1: reply_id_next = {reply_id_reg[7:0], reply_byte};
                    4'd2, 4'd3: flags_next    = {flags_reg[7:0], reply_byte};
                    4'd4, 4'd5: qleft_next    = {qleft_reg[7:0], reply_byte};
                    4'd6, 4'd7: aleft_next    = {aleft_reg[7:0], reply_byte};
                    default: ;
                endcase
                hdr_idx_next = hdr_idx_reg + 4'd1;
                if (hdr_idx_reg == 4'd11) begin
                    hdr_idx_next = 4'd0;
                    if (reply_id_reg != expected_txid)
                        phase_step = PH_REJ_TXID;
                    else if (!flags_reg[15])
                        phase_step = PH_REJ_NOTREPLY;
                    else if (flags_reg[3:0] != 4'd0)
                        phase_step = PH_REJ_RCODE;
                    else if (aleft_reg == 16'd0)
                        phase_step = PH_REJ_NOANS;
                    else
                        phase_step = (qleft_reg != 16'd0) ? PH_QNAME : PH_ANAME;
                end
            end
            PH_QNAME, PH_ANAME: begin
                if (reply_byte[7:6] == 2'b11) begin
                    phase_step = (phase_reg == PH_QNAME) ? PH_QPTR : PH_APTR;
                end else if (reply_byte == 8'd0) begin
                    phase_step   = (phase_reg == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
                    fix_idx_next = 4'd0;
                end else begin
                    label_next = reply_byte;
                    phase_step = (phase_reg == PH_QNAME) ? PH_QLABEL : PH_ALABEL;
                end
            end
            PH_QLABEL: begin
                label_next = label_dec;
                if (label_dec == 8'd0) phase_step = PH_QNAME;
            end
            PH_ALABEL: begin
                label_next = label_dec;
                if (label_dec == 8'd0) phase_step = PH_ANAME;
            end
            PH_QPTR: begin
                phase_step   = PH_QFIXED;
                fix_idx_next = 4'd0;
            end
            PH_APTR: begin
                phase_step   = PH_AFIXED;
                fix_idx_next = 4'd0;
            end
            PH_QFIXED: begin
                fix_idx_next = fix_idx_reg + 4'd1;
                if (fix_idx_reg == 4'd3) begin
                    fix_idx_next = 4'd0;
                    qleft_next   = qleft_dec;
                    phase_step   = (qleft_dec != 16'd0) ? PH_QNAME : PH_ANAME;
                end
            end
            PH_AFIXED: begin
                case (fix_idx_reg) inside
                    4'd0, 4'd1:             rtype_next = {rtype_reg[7:0], reply_byte};
                    4'd4, 4'd5, 4'd6, 4'd7: ttl_next   = {ttl_reg[23:0], reply_byte};
                    4'd8, 4'd9:             rdlen_next = {rdlen_reg[7:0], reply_byte};
                    default: ;
                endcase
                fix_idx_next = fix_idx_reg + 4'd1;
                if (fix_idx_reg == 4'd9) begin
                    fix_idx_next = 4'd0;
                    if (rdlen_full != 16'd4) rtype_next = 16'd0;
                    if (rdlen_full == 16'd0) begin
                        aleft_next = aleft_dec;
                        phase_step = (aleft_dec != 16'd0) ? PH_ANAME : PH_DONE;
                    end else begin
                        phase_step = PH_ARDATA;
                    end
                end
            end
            PH_ARDATA: begin
                addr_next  = {addr_reg[23:0], reply_byte};
                rdlen_next = rdlen_dec;
                if (rdlen_dec == 16'd0) begin
                    if (rtype_reg == 16'd1) begin
                        found_next = found_reg + 16'd1;
                        emit_a     = 1'b1;
                    end
                    aleft_next = aleft_dec;
                    phase_step = (aleft_dec != 16'd0) ? PH_ANAME : PH_DONE;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        status_rcode = flags_next[3:0];
        unique case (phase_step)
            PH_HEADER: begin
                status       = dra_pkg::ST_SHORT;
                status_rcode = 4'd0;
            end
            PH_REJ_TXID:     status = dra_pkg::ST_TXID_BAD;
            PH_REJ_NOTREPLY: status = dra_pkg::ST_NOT_REPLY;
            PH_REJ_RCODE:    status = dra_pkg::ST_RCODE_ERR;
            PH_REJ_NOANS:    status = dra_pkg::ST_NO_ANSWERS;
            default:
                status = (found_next != 16'd0) ? dra_pkg::ST_OK : dra_pkg::ST_NO_A;
        endcase
    end

    always_comb begin
        pair_out.emit_a = emit_a;
        pair_out.emit_s = last_byte;
        pair_out.addr   = addr_next;
        pair_out.ttl    = ttl_reg;
        pair_out.status = status;
        pair_out.rcode  = emit_a ? flags_reg[3:0] : status_rcode;
        pair_out.count  = found_next;
        pair_valid      = byte_en && (emit_a || last_byte);
        phase_next      = last_byte ? PH_HEADER : phase_step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_en && last_byte)) begin
            phase_reg    <= PH_HEADER;
            hdr_idx_reg  <= 4'd0;
            flags_reg    <= 16'd0;
            reply_id_reg <= 16'd0;
            qleft_reg    <= 16'd0;
            aleft_reg    <= 16'd0;
            label_reg    <= 8'd0;
            fix_idx_reg  <= 4'd0;
            rtype_reg    <= 16'd0;
            ttl_reg      <= 32'd0;
            rdlen_reg    <= 16'd0;
            addr_reg     <= 32'd0;
            found_reg    <= 16'd0;
        end else if (byte_en) begin
            phase_reg    <= phase_next;
            hdr_idx_reg  <= hdr_idx_next;
            flags_reg    <= flags_next;
            reply_id_reg <= reply_id_next;
            qleft_reg    <= qleft_next;
            aleft_reg    <= aleft_next;
            label_reg    <= label_next;
            fix_idx_reg  <= fix_idx_next;
            rtype_reg    <= rtype_next;
            ttl_reg      <= ttl_next;
            rdlen_reg    <= rdlen_next;
            addr_reg     <= addr_next;
            found_reg    <= found_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dra_out_queue.sv =====
// DNS reply A-record parser: two-entry result queue.
// Depends on dra_pkg; splits each stored pair into one or two output words.
`default_nettype none

module dra_out_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire dra_pkg::pair_t     push_pair,
    output logic                    has_room,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output dra_pkg::res_t           out_res
);

    dra_pkg::pair_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           a_sent_reg, a_sent_next;

    dra_pkg::pair_t head;
    logic           send_a;
    logic           pop;

    assign head      = entry_reg[rd_ptr_reg];
    assign out_valid = (count_reg != 2'd0);
    assign has_room  = (count_reg != 2'd2);
    assign send_a    = head.emit_a && !a_sent_reg;
    assign pop       = out_valid && out_ready && !(send_a && head.emit_s);

    always_comb begin
        out_res.kind   = send_a ? dra_pkg::KIND_A_RECORD : dra_pkg::KIND_STATUS;
        out_res.addr   = send_a ? head.addr : 32'd0;
        out_res.ttl    = send_a ? head.ttl : 32'd0;
        out_res.status = send_a ? dra_pkg::ST_OK : head.status;
        out_res.rcode  = head.rcode;
        out_res.count  = head.count;

        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        a_sent_next = a_sent_reg;
        if (pop)
            a_sent_next = 1'b0;
        else if (out_valid && out_ready && send_a)
            a_sent_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_pair;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            a_sent_reg <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            a_sent_reg <= a_sent_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dns_reply_a_record_parser.sv =====
// DNS reply A-record parser, top level: txid register, parser, result queue.
// Depends on dra_pkg, dra_parser and dra_out_queue.
//
// Takes one reply byte per cycle while s_tready is high and parses it in the
// same cycle that it is accepted; the results of that byte land in a two-entry
// queue in front of the m_ side. s_tready stays high while the queue has a free
// entry, so an ever-ready consumer gives one byte per cycle, with a gap only
// where a two-word entry fills the queue. A byte that completes an A record
// and also carries tlast yields two words (the A record, then the status),
// which leave in turn from one queue entry. Results appear no earlier than the cycle after their byte.
`default_nettype none

module dns_reply_a_record_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,   // expected_txid
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // reply_byte
    input  wire logic        s_tlast,       // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] ipv4_address, [63:32] ttl_seconds, [66:64] reply_status,
    // [70:67] server_rcode, [86:71] a_record_count, [87] zero
    output logic [dra_pkg::TDATA_W-1:0] m_tdata,
    output logic             m_tuser        // result_kind
);

    logic [15:0]    txid_reg;
    dra_pkg::pair_t pair;
    logic           pair_valid;
    logic           has_room;
    logic           byte_en;
    dra_pkg::res_t  res;

    assign s_tready = has_room;
    assign byte_en  = s_tvalid && has_room;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            txid_reg <= 16'd0;
        else if (cfg_wr_en)
            txid_reg <= cfg_wr_data;
    end

    dra_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .byte_en       (byte_en),
        .reply_byte    (s_tdata),
        .last_byte     (s_tlast),
        .expected_txid (txid_reg),
        .pair_out      (pair),
        .pair_valid    (pair_valid)
    );

    dra_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (pair_valid),
        .push_pair (pair),
        .has_room  (has_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {1'b0, res.count, res.rcode, res.status, res.ttl, res.addr};
    assign m_tuser = res.kind;

`ifndef NO_ASSERTIONS
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result queue not empty after reset");

    a_full_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    a_record_status_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == dra_pkg::KIND_A_RECORD) |-> m_tdata[66:64] == dra_pkg::ST_OK)
        else $error("A record word carries a nonzero status");

    a_record_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == dra_pkg::KIND_A_RECORD) |-> m_tdata[86:71] != 16'd0)
        else $error("A record word with zero record count");
`endif

endmodule

`default_nettype wire
